[sv/streaming_group_aggregator_defines.svh]
// Assertion macros used by the aggregator checker.
`ifndef STREAMING_GROUP_AGGREGATOR_DEFINES_SVH
`define STREAMING_GROUP_AGGREGATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SGA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sga check failed");

// Next-cycle implication, disabled during reset.
`define SGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sga check failed");

`endif

[sv/sga_pkg.sv]
// Shared types and constants of the streaming group aggregator.
package sga_pkg;

    localparam logic [2:0] FUNC_SUM   = 3'd0;
    localparam logic [2:0] FUNC_MAX   = 3'd1;
    localparam logic [2:0] FUNC_MIN   = 3'd2;
    localparam logic [2:0] FUNC_COUNT = 3'd3;
    localparam logic [2:0] FUNC_AVG   = 3'd4;

    // 1.0 in Q.16 fixed point
    localparam logic [63:0] FIX_ONE = 64'h0000_0000_0001_0000;

    localparam int DIGIT_BITS = 8;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul_step;
        logic add_x;
        logic abs_load;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic avg_path;
    } dp_status_t;

endpackage

[sv/sga_datapath.sv]
// Datapath: accumulator state, multiply and divide units, result selection.
module sga_datapath #(
    parameter int VALUE_BITS = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         start_group,
    input  sga_pkg::dp_cmd_t             cmd,
    output sga_pkg::dp_status_t          status,
    output logic signed [VALUE_BITS-1:0] aggregate,
    output logic [COUNT_BITS-1:0]        items_seen,
    output logic                         overflowed
);

    localparam int V  = VALUE_BITS;
    localparam int C  = COUNT_BITS;
    localparam int DB = sga_pkg::DIGIT_BITS;
    localparam int MW = ((C + DB - 1) / DB) * DB;
    localparam int PW = V + MW;

    localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
    localparam logic signed [V-1:0] ONE  = (V > 17) ? V'(sga_pkg::FIX_ONE) : VMAX;

    logic [2:0]          func_reg;
    logic signed [V-1:0] acc_reg, acc_next;
    logic [C-1:0]        count_reg, count_next;
    logic                open_reg;
    logic                ovf_reg, ovf_next;

    logic signed [V-1:0] x_reg;
    logic                first_reg;
    logic [C-1:0]        n_reg;
    logic [MW-1:0]       mplier_reg;
    logic [V-1:0]        mcand_reg;
    logic                acc_neg_reg;
    logic [PW-1:0]       prod_reg;
    logic signed [PW:0]  d_reg;
    logic                neg_reg;
    logic [V-1:0]        dlo_reg;
    logic [C-1:0]        rem_reg;
    logic [V-1:0]        q_reg;

    logic [C-1:0]        count_inc;
    logic [V+DB-1:0]     pp;
    logic signed [PW:0]  prod_s;
    logic signed [PW:0]  x_ext;
    logic [PW:0]         d_mag;
    logic [C:0]          trial;
    logic                trial_ge;
    logic signed [V:0]   sum_w;
    logic signed [V-1:0] avg_res;

    assign count_inc = (count_reg == {C{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign pp        = mcand_reg * mplier_reg[MW-1 -: DB];
    assign prod_s    = signed'({1'b0, prod_reg});
    assign x_ext     = (PW+1)'(x_reg);
    assign d_mag     = d_reg[PW] ? unsigned'(-d_reg) : unsigned'(d_reg);
    assign trial     = {rem_reg, dlo_reg[V-1]};
    assign trial_ge  = trial >= {1'b0, n_reg};
    assign sum_w     = (V+1)'(acc_reg) + (V+1)'(x_reg);
    assign avg_res   = neg_reg ? signed'(-q_reg) : signed'(q_reg);

    assign status.avg_path = (func_reg == sga_pkg::FUNC_AVG) && !first_reg;

    always_comb
    begin
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        count_next = count_inc;
        if (first_reg)
        begin
            acc_next   = (func_reg == sga_pkg::FUNC_COUNT) ? ONE : x_reg;
            count_next = C'(1);
            ovf_next   = 1'b0;
        end
        else
        begin
            case (func_reg)
                sga_pkg::FUNC_SUM:
                begin
                    if (sum_w[V] != sum_w[V-1])
                    begin
                        acc_next = sum_w[V] ? VMIN : VMAX;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum_w[V-1:0];
                    end
                end
                sga_pkg::FUNC_MAX:   acc_next = (x_reg > acc_reg) ? x_reg : acc_reg;
                sga_pkg::FUNC_MIN:   acc_next = (x_reg < acc_reg) ? x_reg : acc_reg;
                sga_pkg::FUNC_COUNT: acc_next = (acc_reg > VMAX - ONE) ? VMAX : acc_reg + ONE;
                sga_pkg::FUNC_AVG:   acc_next = avg_res;
                default:             acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg  <= sga_pkg::FUNC_SUM;
            acc_reg   <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                func_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                acc_reg   <= acc_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
                open_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg     <= value;
            first_reg <= start_group || !open_reg;
        end
        if (cmd.prep)
        begin
            n_reg       <= count_inc;
            mplier_reg  <= MW'(count_inc - 1'b1);
            mcand_reg   <= acc_reg[V-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
            acc_neg_reg <= acc_reg[V-1];
            prod_reg    <= '0;
        end
        if (cmd.mul_step)
        begin
            prod_reg   <= (prod_reg << DB) + PW'(pp);
            mplier_reg <= mplier_reg << DB;
        end
        if (cmd.add_x)
        begin
            d_reg <= acc_neg_reg ? x_ext - prod_s : x_ext + prod_s;
        end
        if (cmd.abs_load)
        begin
            neg_reg <= d_reg[PW];
            dlo_reg <= d_mag[V-1:0];
            rem_reg <= d_mag[V +: C];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? C'(trial - {1'b0, n_reg}) : trial[C-1:0];
            q_reg   <= {q_reg[V-2:0], trial_ge};
            dlo_reg <= dlo_reg << 1;
        end
    end

    assign aggregate  = acc_reg;
    assign items_seen = count_reg;
    assign overflowed = ovf_reg;

endmodule

[sv/sga_controller.sv]
// Controller: sequences accept, multiply, divide and commit of one beat.
module sga_controller #(
    parameter int VALUE_BITS = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sga_pkg::dp_status_t status,
    output sga_pkg::dp_cmd_t    cmd
);

    localparam int CNT_W     = $clog2(VALUE_BITS);
    localparam int MUL_STEPS = (COUNT_BITS + sga_pkg::DIGIT_BITS - 1) / sga_pkg::DIGIT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_ADD,
        S_ABS,
        S_DIV,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = status.avg_path ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_x  = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[sv/streaming_group_aggregator.sv]
// Top level of the streaming group aggregator (sum, max, min, count, average).
//
//   port group   direction   handshake          payload
//   in           sink        in_valid/ready     value, start_group
//   out          source      out_valid/ready    aggregate, items_seen, overflowed
//   cfg          sink        cfg_wr_en          cfg_wr_data (aggregate function)
//
// Sum, max, min and count go from accept through prepare to commit; average
// also passes the 8-bit-per-cycle multiplier and the 1-bit-per-cycle
// restoring divider before it commits.
// A new beat is taken while the previous result waits in the output register.
// Reset clears the accumulator, count, overflow flag and group state.
module streaming_group_aggregator #(
    parameter int VALUE_BITS = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         start_group,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [VALUE_BITS-1:0] aggregate,
    output logic [COUNT_BITS-1:0]        items_seen,
    output logic                         overflowed
);

    sga_pkg::dp_cmd_t    cmd;
    sga_pkg::dp_status_t status;

    sga_controller #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sga_datapath #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .value      (value),
        .start_group(start_group),
        .cmd        (cmd),
        .status     (status),
        .aggregate  (aggregate),
        .items_seen (items_seen),
        .overflowed (overflowed)
    );

endmodule

[sv/sga_checker.sv]
// Port-level checker for the aggregator and its bind.
`include "streaming_group_aggregator_defines.svh"

module sga_checker #(
    parameter int VALUE_BITS = 48,
    parameter int COUNT_BITS = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [VALUE_BITS-1:0] aggregate,
    input logic [COUNT_BITS-1:0]        items_seen,
    input logic                         overflowed
);

    `SGA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `SGA_ASSERT_NOW(a_result_has_count, clk, rst_n, out_valid, items_seen != '0)
    `SGA_ASSERT_NOW(a_first_no_overflow, clk, rst_n,
                    out_valid && items_seen == COUNT_BITS'(1), !overflowed)
    `SGA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(aggregate) && $stable(items_seen)
                     && $stable(overflowed))

endmodule

bind streaming_group_aggregator sga_checker #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
) u_sga_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .aggregate (aggregate),
    .items_seen(items_seen),
    .overflowed(overflowed)
);

[dv/tb_streaming_group_aggregator.sv]
// Self-checking testbench for the streaming group aggregator: random handshakes, checked results.
`timescale 1ns / 100ps

module tb_streaming_group_aggregator;

    localparam int VB = 48;
    localparam int CB = 32;
    localparam int LIMIT = 1_000_000;
    localparam int LONG_HOLD = 400;
    localparam int N_PHASES = 14;
    localparam int PHASE_BEATS = 125;

    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic signed [VB-1:0] ONE = sga_pkg::FIX_ONE[VB-1:0];
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    typedef struct packed {
        logic signed [VB-1:0] value;
        logic                 start_group;
    } beat_t;

    typedef struct packed {
        logic signed [VB-1:0] aggregate;
        logic [CB-1:0]        items_seen;
        logic                 overflowed;
    } agg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_wr_data = 3'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [VB-1:0] value = '0;
    logic start_group = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [VB-1:0] aggregate;
    logic [CB-1:0] items_seen;
    logic overflowed;

    beat_t pending_beats[$];
    agg_result_t agg_expected[$];

    logic [2:0] agg_sel = sga_pkg::FUNC_SUM;
    logic signed [VB-1:0] acc_model = '0;
    logic [CB-1:0] count_model = '0;
    logic group_open_model = 1'b0;
    logic sticky_ovf_model = 1'b0;

    bit idle_on = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int fail_cnt = 0;
    int cycle_count = 0;

    streaming_group_aggregator #(
        .VALUE_BITS(VB),
        .COUNT_BITS(CB)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .start_group(start_group),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .aggregate  (aggregate),
        .items_seen (items_seen),
        .overflowed (overflowed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic agg_result_t apply_aggregate(logic signed [VB-1:0] x, logic sg);
        logic signed [VB:0] total;
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] quo;
        agg_result_t res;
        if (sg || !group_open_model)
        begin
            acc_model = (agg_sel == sga_pkg::FUNC_COUNT) ? ONE : x;
            count_model = CB'(1);
            sticky_ovf_model = 1'b0;
            group_open_model = 1'b1;
        end
        else
        begin
            if (count_model != CMAX)
                count_model = count_model + 1'b1;
            case (agg_sel)
                sga_pkg::FUNC_SUM:
                begin
                    total = $signed({acc_model[VB-1], acc_model}) + $signed({x[VB-1], x});
                    if (total > VMAX)
                    begin
                        acc_model = VMAX;
                        sticky_ovf_model = 1'b1;
                    end
                    else if (total < VMIN)
                    begin
                        acc_model = VMIN;
                        sticky_ovf_model = 1'b1;
                    end
                    else
                        acc_model = total[VB-1:0];
                end
                sga_pkg::FUNC_MAX:
                    if (x > acc_model)
                        acc_model = x;
                sga_pkg::FUNC_MIN:
                    if (x < acc_model)
                        acc_model = x;
                sga_pkg::FUNC_COUNT:
                    acc_model = (acc_model > VMAX - ONE) ? VMAX : acc_model + ONE;
                sga_pkg::FUNC_AVG:
                begin
                    den = $signed({{(128-CB){1'b0}}, count_model});
                    num = $signed({{(128-VB){acc_model[VB-1]}}, acc_model}) * (den - 1)
                        + $signed({{(128-VB){x[VB-1]}}, x});
                    quo = num / den;
                    acc_model = quo[VB-1:0];
                end
                default:
                    ;
            endcase
        end
        res.aggregate = acc_model;
        res.items_seen = count_model;
        res.overflowed = sticky_ovf_model;
        return res;
    endfunction

    function automatic logic signed [VB-1:0] pick_value();
        int r;
        logic [63:0] raw;
        logic signed [20:0] sm;
        logic signed [40:0] md;
        logic signed [VB-1:0] v;
        r = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        sm = raw[20:0];
        md = raw[40:0];
        if (r < 10)
        begin
            case ($urandom_range(0, 4))
                0: v = VMAX;
                1: v = VMIN;
                2: v = '0;
                3: v = 1;
                default: v = -1;
            endcase
        end
        else if (r < 50)
            v = VB'(sm);
        else if (r < 75)
            v = VB'(md);
        else
            v = raw[VB-1:0];
        return v;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            start_group <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_beats.size() != 0)
            begin
                beat_t b;
                b = pending_beats.pop_front();
                in_valid <= 1'b1;
                value <= b.value;
                start_group <= b.start_group;
                send_gap <= draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (recv_stall > 0)
        begin
            out_ready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_ready <= 1'b0;
            recv_stall <= LONG_HOLD;
            hold_served <= hold_requests;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_stall <= draw_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            agg_expected.push_back(apply_aggregate(value, start_group));
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (agg_expected.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected beat: aggregate=%0d items_seen=%0d overflowed=%0b",
                             aggregate, items_seen, overflowed);
            end
            else
            begin
                agg_result_t e;
                e = agg_expected.pop_front();
                if (e.aggregate !== aggregate || e.items_seen !== items_seen
                    || e.overflowed !== overflowed)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: exp agg=%0d cnt=%0d ovf=%0b, got agg=%0d cnt=%0d ovf=%0b",
                                 e.aggregate, e.items_seen, e.overflowed,
                                 aggregate, items_seen, overflowed);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || agg_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_function(input logic [2:0] f);
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= f;
        agg_sel = f;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_beat(input logic signed [VB-1:0] v, input logic sg);
        beat_t b;
        b.value = v;
        b.start_group = sg;
        pending_beats.push_back(b);
    endtask

    task automatic run_random_phase(input logic [2:0] f, input bit gaps, input bit hold);
        int made;
        int glen;
        logic sg;
        made = 0;
        set_function(f);
        idle_on = gaps;
        if (hold)
        begin
            @(negedge clk);
            hold_requests++;
        end
        while (made < PHASE_BEATS)
        begin
            glen = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 60);
            for (int i = 0; i < glen && made < PHASE_BEATS; i++)
            begin
                if (i == 0)
                    sg = ($urandom_range(0, 19) != 0);
                else
                    sg = ($urandom_range(0, 39) == 0);
                push_beat(pick_value(), sg);
                made++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        logic [2:0] plan [N_PHASES];
        plan = '{sga_pkg::FUNC_SUM, sga_pkg::FUNC_AVG, sga_pkg::FUNC_MAX, sga_pkg::FUNC_MIN,
                 sga_pkg::FUNC_COUNT, FUNC_RSVD5, sga_pkg::FUNC_AVG, sga_pkg::FUNC_SUM,
                 FUNC_RSVD6, sga_pkg::FUNC_MIN, FUNC_RSVD7, sga_pkg::FUNC_MAX,
                 sga_pkg::FUNC_AVG, sga_pkg::FUNC_SUM};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_function(sga_pkg::FUNC_SUM);
        push_beat(VMAX, 1'b0);
        push_beat(VMAX, 1'b0);
        push_beat(-1, 1'b0);
        push_beat(VMIN, 1'b1);
        push_beat(VMIN, 1'b0);
        push_beat(1, 1'b0);
        push_beat(VMAX, 1'b1);
        set_function(sga_pkg::FUNC_COUNT);
        push_beat(0, 1'b0);
        push_beat(123, 1'b1);
        push_beat(VMIN, 1'b0);
        set_function(sga_pkg::FUNC_MAX);
        push_beat(0, 1'b1);
        push_beat(VMAX, 1'b0);
        push_beat(VMIN, 1'b0);
        set_function(sga_pkg::FUNC_MIN);
        push_beat(5, 1'b0);
        push_beat(VMIN, 1'b0);
        set_function(sga_pkg::FUNC_AVG);
        push_beat(VMAX, 1'b1);
        push_beat(VMAX, 1'b0);
        push_beat(VMIN, 1'b0);
        push_beat(-3, 1'b0);
        push_beat(7, 1'b0);
        set_function(FUNC_RSVD5);
        push_beat(99, 1'b0);
        push_beat(-42, 1'b1);
        set_function(FUNC_RSVD6);
        push_beat(VMAX, 1'b0);
        set_function(FUNC_RSVD7);
        push_beat(VMIN, 1'b1);
        push_beat(8, 1'b0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++)
            run_random_phase(plan[p], (p % 4) != 3, (p == 1) || (p == 7));

        wait_drained();
        repeat (100) @(posedge clk);
        fail_cnt += agg_expected.size();
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
